// ----- rtl/rct_pkg.sv -----
// Shared types and constants for the relative compare timer.
// No dependencies; compiled first.
package rct_pkg;

    localparam int DATA_W          = 32;
    localparam int REQ_W           = 3;
    localparam int COUNT_WIDTH_DEF = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 3'd0,
        REQ_SCHEDULE = 3'd1,
        REQ_CANCEL   = 3'd2,
        REQ_RESET    = 3'd3,
        REQ_READ     = 3'd4
    } t_req_kind;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] delay_ticks;
    } t_req_item;

    typedef struct packed {
        logic              fire;
        logic              was_late;
        logic [DATA_W-1:0] counter_value;
        logic [DATA_W-1:0] late_total;
        logic [DATA_W-1:0] late_amount;
    } t_rsp_item;

endpackage

// ----- rtl/rct_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type set by the instantiating level, normally from rct_pkg.
interface rct_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/relative_compare_timer.sv -----
// Relative compare timer: wrapping tick counter with a drift-free one-shot compare.
// Depends on rct_pkg and rct_stream_if.
//
// Usage:
//   i_req carries request beats (req_type, delay_ticks); o_rsp carries exactly one
//   response beat per request (fire, was_late, counter_value, late_total,
//   late_amount), in request order.
//   A request is captured in an input register, evaluated against the timer
//   state by combinational adds and compares, and written to the response
//   register. Throughput is one beat per cycle while the receiver does not stall;
//   the timer state registers are updated once per beat, so each request sees
//   the state left by the one before.
//   When the receiver stalls, the response register holds its beat and the
//   input register holds one more request; i_req.ready drops only when both
//   are full, and rises again in the same cycle that o_rsp.ready returns.
//   Reset (i_rst_n low, synchronous) clears the counter, base, compare point,
//   late statistics and both valid flags.
//   req_type codes above read behave as read.
module relative_compare_timer #(
    parameter int COUNT_WIDTH = rct_pkg::COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rct_stream_if.sink   i_req,
    rct_stream_if.source o_rsp
);
    import rct_pkg::*;

    logic                   r_in_valid;
    t_req_item              r_in;
    logic                   r_out_valid;
    t_rsp_item              r_out;

    logic [COUNT_WIDTH-1:0] r_tick,  n_tick;
    logic [COUNT_WIDTH-1:0] r_base,  n_base;
    logic [COUNT_WIDTH-1:0] r_cmp,   n_cmp;
    logic                   r_base_valid, n_base_valid;
    logic                   r_armed, n_armed;
    logic [DATA_W-1:0]      r_late_cnt, n_late_cnt;
    logic [COUNT_WIDTH-1:0] r_late_by, n_late_by;

    logic                   w_advance;
    logic                   w_in_ready;
    logic [COUNT_WIDTH-1:0] w_delay;
    logic [COUNT_WIDTH-1:0] w_base;
    logic [COUNT_WIDTH-1:0] w_elapsed;
    logic [COUNT_WIDTH-1:0] w_tick_inc;
    logic [COUNT_WIDTH-1:0] w_target;
    t_rsp_item              n_out;

    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_in_ready  = !r_in_valid || w_advance;
    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_out;

    assign w_delay    = COUNT_WIDTH'(r_in.delay_ticks);
    assign w_base     = r_base_valid ? r_base : r_tick;
    assign w_elapsed  = r_tick - w_base;
    assign w_tick_inc = r_tick + COUNT_WIDTH'(1);
    assign w_target   = w_base + w_delay + COUNT_WIDTH'(1);

    always_comb begin
        n_tick       = r_tick;
        n_base       = r_base;
        n_cmp        = r_cmp;
        n_base_valid = r_base_valid;
        n_armed      = r_armed;
        n_late_cnt   = r_late_cnt;
        n_late_by    = r_late_by;
        n_out.fire     = 1'b0;
        n_out.was_late = 1'b0;
        case (r_in.req_type)
            REQ_TICK: begin
                n_tick = w_tick_inc;
                if (r_armed && w_tick_inc == r_cmp) begin
                    n_out.fire = 1'b1;
                    n_armed    = 1'b0;
                end
            end
            REQ_SCHEDULE: begin
                n_base_valid = 1'b1;
                if (w_delay < w_elapsed) begin
                    n_late_cnt     = r_late_cnt + DATA_W'(1);
                    n_late_by      = w_elapsed;
                    n_base         = r_tick;
                    n_armed        = 1'b0;
                    n_out.fire     = 1'b1;
                    n_out.was_late = 1'b1;
                end else begin
                    n_cmp   = w_target;
                    n_base  = w_target;
                    n_armed = 1'b1;
                end
            end
            REQ_CANCEL: begin
                n_armed = 1'b0;
            end
            REQ_RESET: begin
                n_base_valid = 1'b0;
                n_base       = '0;
            end
            default: begin
            end
        endcase
        n_out.counter_value = DATA_W'(n_tick);
        n_out.late_total    = n_late_cnt;
        n_out.late_amount   = DATA_W'(n_late_by);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tick       <= '0;
            r_base       <= '0;
            r_cmp        <= '0;
            r_base_valid <= 1'b0;
            r_armed      <= 1'b0;
            r_late_cnt   <= '0;
            r_late_by    <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_tick       <= n_tick;
                r_base       <= n_base;
                r_cmp        <= n_cmp;
                r_base_valid <= n_base_valid;
                r_armed      <= n_armed;
                r_late_cnt   <= n_late_cnt;
                r_late_by    <= n_late_by;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for relative_compare_timer: directed requests, then random
// schedule/tick episodes with noise, checked beat by beat against a built-in predictor.
// Depends on rct_pkg, rct_stream_if and the relative_compare_timer RTL.
module tb;
    import rct_pkg::*;

    localparam int ITEM_TARGET     = 2025;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_READ + 3'd1;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

    class timer_tracker;
        bit [DATA_W-1:0] count_now;
        bit [DATA_W-1:0] base_at;
        bit [DATA_W-1:0] compare_at;
        bit              base_set;
        bit              armed_now;
        bit [DATA_W-1:0] late_events;
        bit [DATA_W-1:0] late_by;
        t_rsp_item       due_responses[$];
        int              errors;

        function new();
            count_now   = '0;
            base_at     = '0;
            compare_at  = '0;
            base_set    = 1'b0;
            armed_now   = 1'b0;
            late_events = '0;
            late_by     = '0;
            errors      = 0;
        endfunction

        function void note_request(t_req_item it);
            t_rsp_item       rsp;
            bit [DATA_W-1:0] elapsed;
            rsp = '0;
            case (it.req_type)
                REQ_TICK: begin
                    count_now = count_now + 1'b1;
                    if (armed_now && count_now == compare_at) begin
                        rsp.fire  = 1'b1;
                        armed_now = 1'b0;
                    end
                end
                REQ_SCHEDULE: begin
                    if (!base_set) begin
                        base_at  = count_now;
                        base_set = 1'b1;
                    end
                    elapsed = count_now - base_at;
                    if (it.delay_ticks < elapsed) begin
                        late_events  = late_events + 1'b1;
                        late_by      = elapsed;
                        base_at      = count_now;
                        armed_now    = 1'b0;
                        rsp.fire     = 1'b1;
                        rsp.was_late = 1'b1;
                    end else begin
                        compare_at = base_at + it.delay_ticks + 1'b1;
                        base_at    = compare_at;
                        armed_now  = 1'b1;
                    end
                end
                REQ_CANCEL: armed_now = 1'b0;
                REQ_RESET: begin
                    base_set = 1'b0;
                    base_at  = '0;
                end
                default: ;
            endcase
            rsp.counter_value = count_now;
            rsp.late_total    = late_events;
            rsp.late_amount   = late_by;
            due_responses.push_back(rsp);
        endfunction

        function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (want !== got) begin
                $display("%0t mismatch %s: expected %0h, got %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_rsp_item got);
            t_rsp_item want;
            if (due_responses.size() == 0) begin
                $display("%0t unexpected beat: expected none, got %p", $time, got);
                errors++;
                return;
            end
            want = due_responses.pop_front();
            report("fire", DATA_W'(want.fire), DATA_W'(got.fire));
            report("was_late", DATA_W'(want.was_late), DATA_W'(got.was_late));
            report("counter_value", want.counter_value, got.counter_value);
            report("late_total", want.late_total, got.late_total);
            report("late_amount", want.late_amount, got.late_amount);
        endfunction

        function int pending();
            return due_responses.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rct_stream_if #(.T(t_req_item)) req_if ();
    rct_stream_if #(.T(t_rsp_item)) rsp_if ();

    relative_compare_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    timer_tracker tracker = new();
    bit           calm;
    int           items_sent;
    int           quiet_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic push(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] delay);
        t_req_item it;
        int        gap;
        it.req_type    = kind;
        it.delay_ticks = delay;
        gap            = draw_wait();
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
        end
        @(negedge i_clk);
        req_if.valid   = 1'b1;
        req_if.payload = it;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.note_request(it);
        items_sent++;
    endtask

    task automatic run_episode();
        logic [DATA_W-1:0] delay;
        int                span;
        int                pick;
        delay = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12);
        push(REQ_SCHEDULE, delay);
        span = $urandom_range(0, (delay > 12) ? 16 : delay + 4);
        repeat (span) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       push(REQ_READ, $urandom);
                1:       push(REQ_CANCEL, $urandom);
                2:       push(REQ_SCHEDULE, $urandom_range(0, 6));
                default: push(REQ_TICK, $urandom);
            endcase
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            push(REQ_RESET, $urandom);
        end else if (pick == 1) begin
            repeat ($urandom_range(1, 4)) push(REQ_W'($urandom_range(0, 7)), $urandom);
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = !calm;
        end
    endtask

    // Response side: stall at random, check every beat taken
    initial begin
        int gap;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_wait();
            repeat (gap) begin
                @(negedge i_clk);
                rsp_if.ready = 1'b0;
            end
            @(negedge i_clk);
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            tracker.check_response(rsp_if.payload);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        calm           = 1'b0;
        items_sent     = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push(REQ_READ, '0);
        push(REQ_SPARE_FIRST, 32'hFFFF_FFFF);
        push(REQ_SPARE_FIRST + 3'd1, 32'h5555_5555);
        push(REQ_SPARE_LAST, 32'hAAAA_AAAA);
        push(REQ_CANCEL, '0);
        push(REQ_SCHEDULE, '0);
        push(REQ_TICK, '0);
        push(REQ_TICK, '1);
        push(REQ_SCHEDULE, '0);
        push(REQ_SCHEDULE, 32'd2);
        push(REQ_CANCEL, '0);
        repeat (3) push(REQ_TICK, '0);
        push(REQ_RESET, '0);
        push(REQ_SCHEDULE, 32'hFFFF_FFFF);
        push(REQ_RESET, '0);
        push(REQ_TICK, '0);
        push(REQ_SCHEDULE, '0);
        push(REQ_TICK, '0);
        push(REQ_SCHEDULE, 32'd1);
        push(REQ_TICK, '0);
        push(REQ_TICK, '0);
        push(REQ_SCHEDULE, 32'h8000_0000);
        push(REQ_READ, '1);

        while (items_sent < ITEM_TARGET) begin
            run_episode();
        end

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.pending() != 0) begin
            $display("%0t %0d responses never arrived", $time, tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
